// ===== rtl/anfp_pkg.sv =====
// ----------------------------------------------------------------------------
// anfp_pkg
// shared types and constants of the ascii number field parser
// ----------------------------------------------------------------------------
`default_nettype none

package anfp_pkg;

  localparam int MAX_HEX_DIGITS = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 2;

  // number formats
  localparam logic [1:0] FMT_UDEC   = 2'd0;
  localparam logic [1:0] FMT_SDEC   = 2'd1;
  localparam logic [1:0] FMT_HEX    = 2'd2;
  localparam logic [1:0] FMT_HEXSEP = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_FORMAT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECIMAL_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEX_MAX_DIGITS = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       begin_req;
  } in_t;

  typedef struct packed {
    logic        taken;
    logic        done_res;
    logic        ok;
    logic [63:0] value;
  } out_t;

  // character after classification
  typedef struct packed {
    logic       begin_req;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;
    logic       is_minus;
    logic       is_sep;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

endpackage

`default_nettype wire

// ===== rtl/anfp_front.sv =====
// ----------------------------------------------------------------------------
// anfp_front
// accepts characters, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module anfp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire anfp_pkg::in_t in_data,
  output logic               in_full,
  output anfp_pkg::link_t    q_out,
  input  wire logic          q_pop
);
  import anfp_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push, pop;
  logic [7:0] c;

  always_comb begin
    c = in_data.char_in;
    cls.begin_req = in_data.begin_req;
    cls.is_dec    = (c >= 8'h30) && (c <= 8'h39);
    cls.is_hex    = 1'b1;
    cls.nib       = 4'd0;
    if (cls.is_dec) begin
      cls.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // a..f and A..F share the low three bits
      cls.nib = 4'd9 + {1'b0, c[2:0]};
    end else begin
      cls.is_hex = 1'b0;
    end
    cls.is_minus = (c == 8'h2D);
    cls.is_sep   = (c == 8'h2D) || (c == 8'h2E) || (c == 8'h2C) || (c == 8'h7C);
  end

  assign in_full = (cnt_r == 2'd2);
  assign push    = in_push && !in_full;
  assign pop     = q_pop && (cnt_r != 2'd0);

  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/anfp_back.sv =====
// ----------------------------------------------------------------------------
// anfp_back
// parse state, configuration registers and the two-entry result queue
// ----------------------------------------------------------------------------
`default_nettype none

module anfp_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire anfp_pkg::link_t                q_in,
  output logic                                q_pop,
  input  wire logic                           cfg_we,
  input  wire logic [anfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [anfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output anfp_pkg::out_t                      out_data
);
  import anfp_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  logic [1:0]  fmt_r;
  logic [31:0] dlim_r;
  logic [4:0]  hmax_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic        seen_r, seen_nxt;
  logic        neg_r, neg_nxt;

  out_t        res;
  logic        fire;

  out_t        mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        opop;

  assign fire  = q_in.valid && (cnt_r != 2'd2);
  assign q_pop = fire;

  always_comb begin
    item_t       it;
    logic        first;
    logic [63:0] cand;
    logic [63:0] limit;
    logic [4:0]  maxd;
    logic [4:0]  cnt_inc;
    it        = q_in.item;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    seen_nxt  = seen_r;
    neg_nxt   = neg_r;
    res       = '0;
    if (it.begin_req) begin
      phase_nxt = PH_FIRST;
      acc_nxt   = '0;
      dcnt_nxt  = '0;
      seen_nxt  = 1'b0;
      neg_nxt   = 1'b0;
    end
    first = (phase_nxt == PH_FIRST);
    cand  = (acc_nxt << 3) + (acc_nxt << 1) + {60'd0, it.nib};
    limit = (fmt_r == FMT_UDEC) ? {32'd0, dlim_r} : {32'd0, 32'hFFFF_FFFF};
    if (hmax_r == 5'd0) begin
      maxd = 5'd1;
    end else if (hmax_r > 5'(MAX_HEX_DIGITS)) begin
      maxd = 5'(MAX_HEX_DIGITS);
    end else begin
      maxd = hmax_r;
    end
    cnt_inc = dcnt_nxt + 5'd1;
    if (phase_nxt != PH_IDLE) begin
      phase_nxt = PH_RUN;
      case (fmt_r)
        FMT_UDEC, FMT_SDEC: begin
          if (it.is_dec) begin
            if (cand > limit) begin
              res.done_res = 1'b1;
            end else begin
              acc_nxt   = cand;
              seen_nxt  = 1'b1;
              res.taken = 1'b1;
            end
          end else if (fmt_r == FMT_SDEC && first && it.is_minus) begin
            neg_nxt   = 1'b1;
            res.taken = 1'b1;
          end else if (!seen_nxt) begin
            res.done_res = 1'b1;
          end else if (fmt_r == FMT_UDEC) begin
            res.done_res = 1'b1;
            res.ok       = 1'b1;
            res.value    = acc_nxt;
          end else if (acc_nxt > 64'h7FFF_FFFF) begin
            res.done_res = 1'b1;
          end else begin
            res.done_res = 1'b1;
            res.ok       = 1'b1;
            res.value    = neg_nxt ? {32'd0, ~acc_nxt[31:0] + 32'd1} : acc_nxt;
          end
        end
        default: begin
          if (fmt_r == FMT_HEXSEP && it.is_sep) begin
            res.taken = 1'b1;
          end else if (!it.is_hex) begin
            res.done_res = 1'b1;
            res.ok       = (dcnt_nxt != 5'd0);
            res.value    = res.ok ? acc_nxt : 64'd0;
          end else begin
            acc_nxt   = {acc_nxt[59:0], it.nib};
            dcnt_nxt  = cnt_inc;
            res.taken = 1'b1;
            if (cnt_inc >= maxd) begin
              res.done_res = 1'b1;
              res.ok       = 1'b1;
              res.value    = {acc_r[59:0], it.nib} & {64{!it.begin_req}} |
                             {60'd0, it.nib} & {64{it.begin_req}};
            end
          end
        end
      endcase
      if (res.done_res) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_UDEC;
      dlim_r  <= 32'hFFFF_FFFF;
      hmax_r  <= 5'(MAX_HEX_DIGITS);
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      dcnt_r  <= '0;
      seen_r  <= 1'b0;
      neg_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUMBER_FORMAT:  fmt_r  <= cfg_data[1:0];
          CFG_DECIMAL_LIMIT:  dlim_r <= cfg_data;
          CFG_HEX_MAX_DIGITS: hmax_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (fire) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        dcnt_r  <= dcnt_nxt;
        seen_r  <= seen_nxt;
        neg_r   <= neg_nxt;
      end
    end
  end

  // result queue
  assign out_empty = (cnt_r == 2'd0);
  assign opop      = out_pop && !out_empty;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r ^ fire;
      rd_ptr_r <= rd_ptr_r ^ opop;
      cnt_r    <= cnt_r + {1'b0, fire} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ascii_number_field_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_number_field_parser
// parses decimal or hex numbers from a stream of ascii characters
// ----------------------------------------------------------------------------
// Input queue: present a word (char_in, begin_req) on in_data with in_push
// high; it is taken on a clock edge where in_full is low. Each character
// gives exactly one result word (taken, done_res, ok, value), read from
// out_data while out_empty is low and removed with out_pop.
// A word accepted at an edge is classified into a two-entry queue; the
// parse state takes it from the head once the result queue has room and
// writes its result word into the result queue. One character per cycle
// is sustained while the result queue has room; the parse state update
// (one decimal multiply-add or hex shift and a bound compare) sets that rate.
// When the reader stalls the result queue fills after two words, the parse
// state stops, and the input queue fills two words later; in_full then
// holds off the sender until out_pop drains a word. Nothing is lost.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait;
// write it only while no word is in flight.
// Synchronous reset (rst_n low) empties both queues, sets the parser idle
// and loads the register defaults: unsigned decimal, limit 0xFFFFFFFF,
// 16 hex digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_number_field_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  input  wire anfp_pkg::in_t                    in_data,
  output logic                                  in_full,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output anfp_pkg::out_t                        out_data,
  input  wire logic                             cfg_we,
  input  wire logic [anfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [anfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import anfp_pkg::*;

  link_t link;
  logic  link_pop;

  anfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_out   (link),
    .q_pop   (link_pop)
  );

  anfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (link),
    .q_pop     (link_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/anfp_checker.sv =====
// ----------------------------------------------------------------------------
// anfp_checker
// port-level checks of the ascii number field parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module anfp_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_empty,
  input wire logic           out_pop,
  input wire anfp_pkg::out_t out_data
);
  import anfp_pkg::*;

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.ok) |-> out_data.done_res)
    else $error("ok without end of number");

  // a consumed last character only happens on a full hex digit count
  a_taken_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.taken && out_data.done_res) |-> out_data.ok)
    else $error("consumed ending character without success");

  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.value != 64'd0)) |-> out_data.ok)
    else $error("value shown without success");

endmodule

bind ascii_number_field_parser anfp_checker u_anfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
